// ===== rtl/rcma_pkg.sv =====
// Shared types, constants and codes of the RNS coefficient modular ALU.
`timescale 1ns / 1ps

package rcma_pkg;

   localparam int LANES      = 4;
   localparam int NUM_MODULI = 4;
   localparam int WORD_W     = 31;
   localparam int FUNC_W     = 3;
   localparam int RIDX_W     = 2;
   localparam int REG_COUNT  = 4;
   localparam int REG_IDX_W  = $clog2(REG_COUNT);
   localparam int ADDR_W     = REG_IDX_W + 2;
   localparam int DATA_W     = 32;
   localparam int STEPS      = WORD_W;
   localparam int CNT_W      = $clog2(STEPS);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [LANES-1:0][WORD_W-1:0] lane_words_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_NEG = 3'd3,
      FUNC_EQ  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MULT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic reduce;
      logic mult;
   } lane_ctl_type;

endpackage

// ===== rtl/rcma_lane.sv =====
// One coefficient lane: bit-serial operand reduction, modular multiply and final op.
`timescale 1ns / 1ps

module rcma_lane (
   input  logic                   clock,
   input  rcma_pkg::lane_ctl_type ctl,
   input  rcma_pkg::func_type     func,
   input  rcma_pkg::word_type     modulus,
   input  rcma_pkg::word_type     a,
   input  rcma_pkg::word_type     b,
   output rcma_pkg::word_type     result,
   output logic                   equal
);
   import rcma_pkg::*;

   word_type a_sh_ff, a_sh_in;
   word_type b_sh_ff, b_sh_in;
   word_type ra_ff, ra_in;
   word_type rb_ff, rb_in;
   word_type acc_ff, acc_in;

   logic [WORD_W:0]   ra_t, rb_t, m_32, add_s, sub_s;
   logic [WORD_W+1:0] mul_t, m_33, m2_33;

   assign m_32  = {1'b0, modulus};
   assign m_33  = {2'b00, modulus};
   assign m2_33 = {1'b0, modulus, 1'b0};

   // Restoring reduction: shift one operand bit in, subtract once if needed.
   assign ra_t = {ra_ff, a_sh_ff[WORD_W-1]};
   assign rb_t = {rb_ff, b_sh_ff[WORD_W-1]};

   // Double and add: 2*acc + bit*ra stays below 3m, so at most one of m or 2m comes off.
   assign mul_t = {1'b0, acc_ff, 1'b0} + (rb_ff[WORD_W-1] ? {2'b00, ra_ff} : '0);

   always_comb begin
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      acc_in  = acc_ff;
      if (ctl.load) begin
         a_sh_in = a;
         b_sh_in = b;
         ra_in   = '0;
         rb_in   = '0;
         acc_in  = '0;
      end else if (ctl.reduce) begin
         a_sh_in = {a_sh_ff[WORD_W-2:0], 1'b0};
         b_sh_in = {b_sh_ff[WORD_W-2:0], 1'b0};
         ra_in   = (ra_t >= m_32) ? WORD_W'(ra_t - m_32) : ra_t[WORD_W-1:0];
         rb_in   = (rb_t >= m_32) ? WORD_W'(rb_t - m_32) : rb_t[WORD_W-1:0];
      end else if (ctl.mult) begin
         rb_in = {rb_ff[WORD_W-2:0], 1'b0};
         priority if (mul_t >= m2_33) begin
            acc_in = WORD_W'(mul_t - m2_33);
         end else if (mul_t >= m_33) begin
            acc_in = WORD_W'(mul_t - m_33);
         end else begin
            acc_in = mul_t[WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      acc_ff  <= acc_in;
   end

   assign add_s = {1'b0, ra_ff} + {1'b0, rb_ff};
   assign sub_s = {1'b0, ra_ff} + m_32 - {1'b0, rb_ff};

   always_comb begin
      unique case (func)
         FUNC_ADD: result = (add_s >= m_32) ? WORD_W'(add_s - m_32) : add_s[WORD_W-1:0];
         FUNC_SUB: result = (ra_ff >= rb_ff) ? WORD_W'(ra_ff - rb_ff) : sub_s[WORD_W-1:0];
         FUNC_MUL: result = acc_ff;
         FUNC_NEG: result = (ra_ff == '0) ? '0 : WORD_W'(modulus - ra_ff);
         default:  result = '0;
      endcase
   end

   assign equal = (ra_ff == rb_ff);

endmodule

// ===== rtl/rcma_merge.sv =====
// Merge stage: fold lane equality into the running flag and register the result.
`timescale 1ns / 1ps

module rcma_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     capture,
   input  rcma_pkg::func_type       func,
   input  logic                     last,
   input  rcma_pkg::lane_words_type lane_res,
   input  logic [rcma_pkg::LANES-1:0] lane_eq,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output rcma_pkg::lane_words_type rsp_res,
   output logic                     rsp_all_equal,
   output logic                     rsp_end_of_run,
   output logic                     out_free
);
   import rcma_pkg::*;

   logic           valid_ff, valid_in;
   logic           eq_ff, eq_in;
   logic           flag_now;
   lane_words_type res_ff;
   logic           all_eq_ff;
   logic           eor_ff;

   assign out_free = !valid_ff || !rsp_stall;

   // Drop the flag on a mismatching equality item; re-arm after the last item.
   assign flag_now = (func == FUNC_EQ && !(&lane_eq)) ? 1'b0 : eq_ff;

   always_comb begin
      valid_in = valid_ff;
      eq_in    = eq_ff;
      if (capture) begin
         valid_in = 1'b1;
         eq_in    = last ? 1'b1 : flag_now;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         eq_ff    <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         eq_ff    <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         res_ff    <= (func == FUNC_EQ) ? '0 : lane_res;
         all_eq_ff <= flag_now;
         eor_ff    <= last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_res        = res_ff;
   assign rsp_all_equal  = all_eq_ff;
   assign rsp_end_of_run = eor_ff;

endmodule

// ===== rtl/rns_coefficient_mod_alu.sv =====
// Top level of the RNS coefficient modular ALU: sequencer, modulus registers, lanes, merge.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake            Payload
//  req_*     in         req_valid/req_stall  func, residue_index, a/b lanes 0..3, last
//  rsp_*     out        rsp_valid/rsp_stall  result lanes 0..3, all_equal, end_of_run
//  csr_*     in/out     APB psel/penable     modulus_0..3 at byte addresses 0, 4, 8, 12
//
//  An item passes from its transfer to its result through the 31-step bit-serial
//  reduction in each lane, plus 31 double-and-add steps for multiply.
//  One item is in the lanes at a time; the next transfer can be taken as soon as a result
//  enters the output register, even while that result is still stalled.
//  Synchronous reset clears the sequencer, the running all-equal flag (to one) and
//  sets every modulus to 2. A stalled result holds in the output register.

module rns_coefficient_mod_alu (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rcma_pkg::FUNC_W-1:0] req_func,
   input  logic [rcma_pkg::RIDX_W-1:0] req_residue_index,
   input  rcma_pkg::word_type         req_a_lane0,
   input  rcma_pkg::word_type         req_a_lane1,
   input  rcma_pkg::word_type         req_a_lane2,
   input  rcma_pkg::word_type         req_a_lane3,
   input  rcma_pkg::word_type         req_b_lane0,
   input  rcma_pkg::word_type         req_b_lane1,
   input  rcma_pkg::word_type         req_b_lane2,
   input  rcma_pkg::word_type         req_b_lane3,
   input  logic                       req_last,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rcma_pkg::word_type         rsp_result_lane0,
   output rcma_pkg::word_type         rsp_result_lane1,
   output rcma_pkg::word_type         rsp_result_lane2,
   output rcma_pkg::word_type         rsp_result_lane3,
   output logic                       rsp_all_equal,
   output logic                       rsp_end_of_run,
   // configuration port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [rcma_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [rcma_pkg::DATA_W-1:0] csr_pwdata,
   output logic [rcma_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import rcma_pkg::*;

   // ---------------- configuration registers ----------------
   word_type                 mod_ff [REG_COUNT];
   logic                     csr_write;
   logic [REG_IDX_W-1:0]     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {{(DATA_W-WORD_W){1'b0}}, mod_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            mod_ff[i] <= WORD_W'(2);
         end
      end else if (csr_write) begin
         mod_ff[csr_idx] <= csr_pwdata[WORD_W-1:0];
      end
   end

   // ---------------- item capture ----------------
   logic                 accepted;
   logic [RIDX_W-1:0]    ridx;
   word_type             m_sel;
   word_type             m_ff;
   func_type             func_ff;
   logic                 last_ff;
   word_type             a_in [LANES];
   word_type             b_in [LANES];

   assign accepted = req_valid && !req_stall;

   // Clamp the basis index to the configured count of moduli.
   assign ridx  = (req_residue_index > RIDX_W'(NUM_MODULI - 1)) ?
                  RIDX_W'(NUM_MODULI - 1) : req_residue_index;
   assign m_sel = mod_ff[ridx];

   assign a_in[0] = req_a_lane0;
   assign a_in[1] = req_a_lane1;
   assign a_in[2] = req_a_lane2;
   assign a_in[3] = req_a_lane3;
   assign b_in[0] = req_b_lane0;
   assign b_in[1] = req_b_lane1;
   assign b_in[2] = req_b_lane2;
   assign b_in[3] = req_b_lane3;

   // A modulus of zero or one behaves as one: every residue collapses to zero.
   always_ff @(posedge clock) begin
      if (accepted) begin
         m_ff    <= (m_sel < WORD_W'(2)) ? WORD_W'(1) : m_sel;
         func_ff <= func_type'(req_func);
         last_ff <= req_last;
      end
   end

   // ---------------- sequencer ----------------
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             step_done;
   logic             out_free;
   logic             capture;
   lane_ctl_type     lane_ctl;

   assign step_done = (cnt_ff == CNT_W'(STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accepted) state_in = ST_REDUCE;
         ST_REDUCE: if (step_done) state_in = (func_ff == FUNC_MUL) ? ST_MULT : ST_FINISH;
         ST_MULT:   if (step_done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lane_ctl  = '0;
      req_stall = 1'b1;
      capture   = 1'b0;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            lane_ctl.load = accepted;
            cnt_in        = '0;
         end
         ST_REDUCE: begin
            lane_ctl.reduce = 1'b1;
            cnt_in          = step_done ? '0 : cnt_ff + 1'b1;
         end
         ST_MULT: begin
            lane_ctl.mult = 1'b1;
            cnt_in        = step_done ? '0 : cnt_ff + 1'b1;
         end
         ST_FINISH: begin
            capture = out_free;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // ---------------- lanes ----------------
   lane_words_type   lane_res;
   logic [LANES-1:0] lane_eq;
   lane_words_type   out_res;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      rcma_lane u_lane (
         .clock   (clock),
         .ctl     (lane_ctl),
         .func    (func_ff),
         .modulus (m_ff),
         .a       (a_in[g]),
         .b       (b_in[g]),
         .result  (lane_res[g]),
         .equal   (lane_eq[g])
      );
   end

   // ---------------- merge and output register ----------------
   rcma_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .capture        (capture),
      .func           (func_ff),
      .last           (last_ff),
      .lane_res       (lane_res),
      .lane_eq        (lane_eq),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_res        (out_res),
      .rsp_all_equal  (rsp_all_equal),
      .rsp_end_of_run (rsp_end_of_run),
      .out_free       (out_free)
   );

   assign rsp_result_lane0 = out_res[0];
   assign rsp_result_lane1 = out_res[1];
   assign rsp_result_lane2 = out_res[2];
   assign rsp_result_lane3 = out_res[3];

   // ---------------- assertions ----------------
   logic res_in_range;

   always_comb begin
      res_in_range = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         if (lane_res[i] >= m_ff) res_in_range = 1'b0;
      end
   end

   a_accept_starts_reduce: assert property (@(posedge clock) disable iff (reset)
      accepted |=> (state_ff == ST_REDUCE) && (cnt_ff == '0))
      else $error("accepted item did not start reduction");

   a_capture_shows_result: assert property (@(posedge clock) disable iff (reset)
      capture |=> rsp_valid)
      else $error("captured result not presented");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      capture |-> res_in_range)
      else $error("lane result not below modulus");

endmodule
